[src/aarm_pkg.sv]
package aarm_pkg;

  typedef struct packed {
    logic signed [15:0] angle;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
  } aarm_in_t;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
  } aarm_out_t;

  // reduced angle and axis, handed from front to back
  typedef struct packed {
    logic signed [31:0] z;
    logic               flip;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } aarm_job_t;

  localparam int AtanCount = 30;
  localparam logic signed [33:0] PiQ28     = 34'sd843314857;
  localparam logic signed [33:0] HalfPiQ28 = 34'sd421657428;
  localparam logic signed [33:0] TwoPiQ28  = 34'sd1686629713;
  localparam logic signed [32:0] GainQ30   = 33'sd652032874;

  function automatic logic signed [31:0] atan_q28(input logic [4:0] k);
    logic signed [31:0] r;
    case (k)
      5'd0: r = 32'sd210828714;  5'd1: r = 32'sd124459457;
      5'd2: r = 32'sd65760959;   5'd3: r = 32'sd33381290;
      5'd4: r = 32'sd16755422;   5'd5: r = 32'sd8385879;
      5'd6: r = 32'sd4193963;    5'd7: r = 32'sd2097109;
      5'd8: r = 32'sd1048571;    5'd9: r = 32'sd524287;
      5'd10: r = 32'sd262144;    5'd11: r = 32'sd131072;
      5'd12: r = 32'sd65536;     5'd13: r = 32'sd32768;
      5'd14: r = 32'sd16384;     5'd15: r = 32'sd8192;
      5'd16: r = 32'sd4096;      5'd17: r = 32'sd2048;
      5'd18: r = 32'sd1024;      5'd19: r = 32'sd512;
      5'd20: r = 32'sd256;       5'd21: r = 32'sd128;
      5'd22: r = 32'sd64;        5'd23: r = 32'sd32;
      5'd24: r = 32'sd16;        5'd25: r = 32'sd8;
      5'd26: r = 32'sd4;         5'd27: r = 32'sd2;
      5'd28: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

[src/axis_angle_rotation_matrix.sv]
// Port     Dir  Meaning
// start    in   request strobe, taken when busy is low
// request  in   angle Q4.12, axis Q1.14
// busy     out  always low: one request per cycle
// done     out  one-cycle strobe marking result
// result   out  nine matrix entries, Q1.14
// One request per cycle; a request passes the front register, the CORDIC
// pipeline (one stage per iteration) and the multiplier stages.
// Reset (rst, synchronous) clears all valid flags; results in flight drop.
// The receiver cannot stall; the front and back never hold each other.
module axis_angle_rotation_matrix import aarm_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  aarm_in_t  request,
  output logic      done,
  output aarm_out_t result
);

  logic      job_valid;
  aarm_job_t job;

  assign busy = 1'b0;

  aarm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .in_item   (request),
    .job_valid (job_valid),
    .job       (job)
  );

  aarm_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .res_valid (done),
    .res       (result)
  );

endmodule

[src/aarm_front.sv]
module aarm_front import aarm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  aarm_in_t  in_item,
  output logic      job_valid,
  output aarm_job_t job
);

  logic signed [33:0] a0, a1, a2, a3, a4;
  logic               flip;

  function automatic logic signed [33:0] wrap(input logic signed [33:0] v);
    logic signed [33:0] r;
    if (v > PiQ28) r = v - TwoPiQ28;
    else if (v < -PiQ28) r = v + TwoPiQ28;
    else r = v;
    return r;
  endfunction

  always_comb begin
    a0 = {{2{in_item.angle[15]}}, in_item.angle, 16'd0};
    a1 = wrap(a0);
    a2 = wrap(a1);
    a3 = wrap(a2);
    flip = 1'b0;
    a4 = a3;
    if (a3 > HalfPiQ28) begin
      a4 = a3 - PiQ28;
      flip = 1'b1;
    end else if (a3 < -HalfPiQ28) begin
      a4 = a3 + PiQ28;
      flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else begin
      job_valid <= in_valid;
    end
    job.z    <= a4[31:0];
    job.flip <= flip;
    job.ax   <= in_item.axis_x;
    job.ay   <= in_item.axis_y;
    job.az   <= in_item.axis_z;
  end

endmodule

[src/aarm_back.sv]
module aarm_back import aarm_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      job_valid,
  input  aarm_job_t job,
  output logic      res_valid,
  output aarm_out_t res
);

  localparam int Steps = (CORDIC_STEPS < AtanCount) ? CORDIC_STEPS : AtanCount;

  // CORDIC pipeline, one iteration per stage
  logic signed [33:0] cx [Steps+1];
  logic signed [33:0] cy [Steps+1];
  logic signed [31:0] cz [Steps+1];
  aarm_job_t          cj [Steps+1];
  logic               cv [Steps+1];

  assign cx[0] = 34'(GainQ30);
  assign cy[0] = '0;
  assign cz[0] = job.z;
  assign cj[0] = job;
  assign cv[0] = job_valid;

  for (genvar k = 0; k < Steps; k++) begin : g_cordic
    logic signed [33:0] dx, dy;
    assign dx = cy[k] >>> k;
    assign dy = cx[k] >>> k;
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[k+1] <= 1'b0;
      end else begin
        cv[k+1] <= cv[k];
      end
      if (!cz[k][31]) begin
        cx[k+1] <= cx[k] - dx;
        cy[k+1] <= cy[k] + dy;
        cz[k+1] <= cz[k] - atan_q28(5'(k));
      end else begin
        cx[k+1] <= cx[k] + dx;
        cy[k+1] <= cy[k] - dy;
        cz[k+1] <= cz[k] + atan_q28(5'(k));
      end
      cj[k+1] <= cj[k];
    end
  end

  // negate on flip, round to Q14
  logic signed [33:0] fx, fy, rx, ry;
  always_comb begin
    fx = cj[Steps].flip ? -cx[Steps] : cx[Steps];
    fy = cj[Steps].flip ? -cy[Steps] : cy[Steps];
    rx = (fx + 34'sd32768) >>> 16;
    ry = (fy + 34'sd32768) >>> 16;
  end

  logic signed [17:0] c1, s1, t1;
  aarm_job_t          j1;
  logic               v1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= cv[Steps];
    c1 <= rx[17:0];
    s1 <= ry[17:0];
    t1 <= 18'sd16384 - rx[17:0];
    j1 <= cj[Steps];
  end

  // axis products and sine terms
  logic signed [31:0] pxx, pyy, pzz, pxy, pxz, pyz;
  logic signed [33:0] sx, sy, sz;
  logic signed [17:0] c2, t2;
  logic               v2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    pxx <= j1.ax * j1.ax;  pyy <= j1.ay * j1.ay;  pzz <= j1.az * j1.az;
    pxy <= j1.ax * j1.ay;  pxz <= j1.ax * j1.az;  pyz <= j1.ay * j1.az;
    sx <= s1 * j1.ax;      sy <= s1 * j1.ay;      sz <= s1 * j1.az;
    c2 <= c1;
    t2 <= t1;
  end

  // t times products
  logic signed [49:0] txx, tyy, tzz, txy, txz, tyz;
  logic signed [33:0] sx3, sy3, sz3;
  logic signed [17:0] c3;
  logic               v3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    txx <= t2 * pxx;  tyy <= t2 * pyy;  tzz <= t2 * pzz;
    txy <= t2 * pxy;  txz <= t2 * pxz;  tyz <= t2 * pyz;
    sx3 <= sx;  sy3 <= sy;  sz3 <= sz;
    c3 <= c2;
  end

  function automatic logic signed [15:0] rsat(input logic signed [51:0] v);
    logic signed [51:0] r;
    logic signed [15:0] o;
    r = (v + 52'sd134217728) >>> 28;
    if (r > 52'sd32767) o = 16'sh7fff;
    else if (r < -52'sd32768) o = 16'sh8000;
    else o = r[15:0];
    return o;
  endfunction

  logic signed [51:0] ec, esx, esy, esz;
  always_comb begin
    ec  = 52'(c3) <<< 28;
    esx = 52'(sx3) <<< 14;
    esy = 52'(sy3) <<< 14;
    esz = 52'(sz3) <<< 14;
  end

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else res_valid <= v3;
    res.r00 <= rsat(52'(txx) + ec);
    res.r01 <= rsat(52'(txy) - esz);
    res.r02 <= rsat(52'(txz) + esy);
    res.r10 <= rsat(52'(txy) + esz);
    res.r11 <= rsat(52'(tyy) + ec);
    res.r12 <= rsat(52'(tyz) - esx);
    res.r20 <= rsat(52'(txz) - esy);
    res.r21 <= rsat(52'(tyz) + esx);
    res.r22 <= rsat(52'(tzz) + ec);
  end

endmodule
